// ===== rtl/vpts_pkg.sv =====
// Shared constants and types for the vertex perspective to screen block.
// Depends on nothing; taken in by the top level.
package vpts_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned RegW     = 64;
  localparam int unsigned SizeW    = 14;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned ClipW    = 50;
  localparam int unsigned MagW     = ClipW;
  localparam int unsigned ProdW    = MagW + SizeW;
  localparam int unsigned NumW     = ProdW + 16;
  localparam int unsigned DivW     = ClipW + 1;
  localparam int unsigned QuotW    = 34;
  localparam int unsigned SumW     = 66;

  typedef enum logic [CfgIdxW-1:0] {
    REG_M_X_01 = 4'd0,
    REG_M_X_23 = 4'd1,
    REG_M_Y_01 = 4'd2,
    REG_M_Y_23 = 4'd3,
    REG_M_W_01 = 4'd4,
    REG_M_W_23 = 4'd5,
    REG_WIDTH  = 4'd6,
    REG_HEIGHT = 4'd7
  } reg_idx_e;

  localparam logic [RegW-1:0]  RstMX01  = 64'd65536;
  localparam logic [RegW-1:0]  RstMY01  = 64'd281474976710656;
  localparam logic [RegW-1:0]  RstMW23  = 64'd281474976710656;
  localparam logic [SizeW-1:0] RstWidth = 14'd640;
  localparam logic [SizeW-1:0] RstHeight = 14'd480;

  typedef struct packed {
    logic [DivW-1:0]       rem;
    logic [QuotW-1:0]      low;
    logic [QuotW-1:0]      quo;
    logic                  ovf;
    logic                  neg;
    logic                  nz;
  } lane_t;

endpackage

// ===== rtl/vertex_perspective_to_screen.sv =====
// Top level: projects one vertex per cycle through the matrix rows, a size
// multiply and a bit-per-stage divider onto screen coordinates. Uses vpts_pkg.
//
// channel   direction  handshake                    payload
// command   in         start_i while !busy_o        vertex_x_i, vertex_y_i, vertex_z_i
// result    out        out_valid_o, one cycle       pix_x_o, pix_y_o, w_zero_o
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// A word passes from start_i to out_valid_o through the multiply, sum, classify,
// size multiply and range check stages, the 34 divider stages and the output stage.
// A new word is taken every cycle; busy_o stays low.
// Reset clears the stage valid bits and loads the register defaults.
// A word with negative clip w is dropped in the classify stage.
module vertex_perspective_to_screen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [vpts_pkg::CoordW-1:0] vertex_x_i,
  input  logic signed [vpts_pkg::CoordW-1:0] vertex_y_i,
  input  logic signed [vpts_pkg::CoordW-1:0] vertex_z_i,
  output logic                           out_valid_o,
  output logic signed [vpts_pkg::CoordW-1:0] pix_x_o,
  output logic signed [vpts_pkg::CoordW-1:0] pix_y_o,
  output logic                           w_zero_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vpts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vpts_pkg::RegW-1:0]      cfg_data_i
);
  import vpts_pkg::*;

  logic [RegW-1:0]  mx01_q, mx23_q, my01_q, my23_q, mw01_q, mw23_q;
  logic [SizeW-1:0] wd_q, ht_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx01_q <= RstMX01;
      mx23_q <= '0;
      my01_q <= RstMY01;
      my23_q <= '0;
      mw01_q <= '0;
      mw23_q <= RstMW23;
      wd_q   <= RstWidth;
      ht_q   <= RstHeight;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_M_X_01: mx01_q <= cfg_data_i;
        REG_M_X_23: mx23_q <= cfg_data_i;
        REG_M_Y_01: my01_q <= cfg_data_i;
        REG_M_Y_23: my23_q <= cfg_data_i;
        REG_M_W_01: mw01_q <= cfg_data_i;
        REG_M_W_23: mw23_q <= cfg_data_i;
        REG_WIDTH:  wd_q   <= cfg_data_i[SizeW-1:0];
        REG_HEIGHT: ht_q   <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // multiply stage
  logic signed [2*CoordW-1:0] pr_q [9];
  logic                       va_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    pr_q[0] <= $signed(mx01_q[31:0])  * vertex_x_i;
    pr_q[1] <= $signed(mx01_q[63:32]) * vertex_y_i;
    pr_q[2] <= $signed(mx23_q[31:0])  * vertex_z_i;
    pr_q[3] <= $signed(my01_q[31:0])  * vertex_x_i;
    pr_q[4] <= $signed(my01_q[63:32]) * vertex_y_i;
    pr_q[5] <= $signed(my23_q[31:0])  * vertex_z_i;
    pr_q[6] <= $signed(mw01_q[31:0])  * vertex_x_i;
    pr_q[7] <= $signed(mw01_q[63:32]) * vertex_y_i;
    pr_q[8] <= $signed(mw23_q[31:0])  * vertex_z_i;
  end

  // row sum stage
  function automatic logic signed [ClipW-1:0] row_sum(
    input logic signed [2*CoordW-1:0] a, b, c,
    input logic [CoordW-1:0] k
  );
    logic signed [SumW-1:0] s;
    s = SumW'(a) + SumW'(b) + SumW'(c) + (SumW'($signed(k)) <<< 16);
    return s[ClipW+15:16];
  endfunction

  logic signed [ClipW-1:0] px_q, py_q, pw_q;
  logic                    vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    px_q <= row_sum(pr_q[0], pr_q[1], pr_q[2], mx23_q[63:32]);
    py_q <= row_sum(pr_q[3], pr_q[4], pr_q[5], my23_q[63:32]);
    pw_q <= row_sum(pr_q[6], pr_q[7], pr_q[8], mw23_q[63:32]);
  end

  // classify stage
  logic [MagW-1:0] magx_q, magy_q;
  logic            negx_c, negy_c, wzc_q, vc_q;
  logic [DivW-1:0] dc_q;
  logic            negxc_q, negyc_q;

  assign negx_c = px_q[ClipW-1];
  assign negy_c = py_q[ClipW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q && !pw_q[ClipW-1];
  end

  always_ff @(posedge clk_i) begin
    magx_q  <= negx_c ? MagW'(-px_q) : MagW'(px_q);
    magy_q  <= negy_c ? MagW'(-py_q) : MagW'(py_q);
    negxc_q <= negx_c;
    negyc_q <= negy_c;
    dc_q    <= {pw_q, 1'b0};
    wzc_q   <= (pw_q == '0);
  end

  // size multiply stage
  logic [ProdW-1:0] mx_q, my_q;
  logic [DivW-1:0]  dd_q;
  logic             vd_q, wzd_q, negxd_q, negyd_q, nzxd_q, nzyd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= magx_q * wd_q;
    my_q    <= magy_q * ht_q;
    dd_q    <= dc_q;
    wzd_q   <= wzc_q;
    negxd_q <= negxc_q;
    negyd_q <= negyc_q;
    nzxd_q  <= (magx_q != '0);
    nzyd_q  <= (magy_q != '0);
  end

  // range check and divider stages
  lane_t           lx_q [QuotW+1];
  lane_t           ly_q [QuotW+1];
  logic [DivW-1:0] dv_q [QuotW+1];
  logic            wz_q [QuotW+1];
  logic            vv_q [QuotW+1];

  function automatic lane_t lane_init(input logic [ProdW-1:0] m, input logic [DivW-1:0] d,
                                      input logic neg, input logic nz);
    lane_t l;
    logic [NumW-1:0] n;
    n     = {m, 16'd0};
    l.ovf = (DivW'(n[NumW-1:QuotW]) >= d);
    l.rem = DivW'(n[NumW-1:QuotW]);
    l.low = n[QuotW-1:0];
    l.quo = '0;
    l.neg = neg;
    l.nz  = nz;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [DivW-1:0] d);
    lane_t r;
    logic [DivW:0] cur;
    logic          ge;
    r   = l;
    cur = {l.rem, l.low[QuotW-1]};
    ge  = (cur >= {1'b0, d});
    r.rem = ge ? DivW'(cur - {1'b0, d}) : DivW'(cur);
    r.low = {l.low[QuotW-2:0], 1'b0};
    r.quo = {l.quo[QuotW-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QuotW; k++) vv_q[k] <= 1'b0;
    end else begin
      vv_q[0] <= vd_q;
      for (int k = 1; k <= QuotW; k++) vv_q[k] <= vv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q[0] <= lane_init(mx_q, dd_q, negxd_q, nzxd_q);
    ly_q[0] <= lane_init(my_q, dd_q, negyd_q, nzyd_q);
    dv_q[0] <= dd_q;
    wz_q[0] <= wzd_q;
    for (int k = 1; k <= QuotW; k++) begin
      lx_q[k] <= lane_step(lx_q[k-1], dv_q[k-1]);
      ly_q[k] <= lane_step(ly_q[k-1], dv_q[k-1]);
      dv_q[k] <= dv_q[k-1];
      wz_q[k] <= wz_q[k-1];
    end
  end

  // output stage
  function automatic logic [CoordW-1:0] finish(input lane_t l, input logic [SizeW-1:0] sz);
    logic [QuotW:0]          qs;
    logic signed [QuotW+2:0] r;
    qs = l.ovf ? (QuotW+1)'(64'd1 << 33) : {1'b0, l.quo};
    if (!l.nz) qs = '0;
    r = l.neg ? -$signed({2'b0, qs}) : $signed({2'b0, qs});
    r = r + $signed((QuotW+3)'({sz, 15'd0}));
    if (r > $signed((QuotW+3)'(64'h7FFF_FFFF)))        return 32'h7FFF_FFFF;
    else if (r < -$signed((QuotW+3)'(64'h8000_0000)))  return 32'h8000_0000;
    else                                               return r[CoordW-1:0];
  endfunction

  logic out_valid_q, w_zero_q;
  logic [CoordW-1:0] sx_q, sy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= vv_q[QuotW];
  end

  always_ff @(posedge clk_i) begin
    sx_q     <= finish(lx_q[QuotW], wd_q);
    sy_q     <= finish(ly_q[QuotW], ht_q);
    w_zero_q <= wz_q[QuotW];
  end

  assign out_valid_o = out_valid_q;
  assign pix_x_o     = $signed(sx_q);
  assign pix_y_o     = $signed(sy_q);
  assign w_zero_o    = w_zero_q;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for vertex_perspective_to_screen: directed table, then random
// configurations and vertices, each result checked against the row's given result if any,
// else an in-bench projection model. Depends on vpts_pkg and the top-level RTL only.
module tb_top;
  import vpts_pkg::*;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        wz;
  } screen_t;

  typedef struct {
    logic [31:0] vx, vy, vz;
    bit          typed;
    screen_t     res;
  } vrow_t;

  localparam int Drain    = 60;
  localparam int WdogMax  = 2000;
  localparam logic [63:0] OneHigh = 64'h0001_0000_0000_0000;
  localparam logic [63:0] NegHigh = 64'hFFFF_0000_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] vertex_x_i = '0, vertex_y_i = '0, vertex_z_i = '0;
  logic out_valid_o;
  logic signed [31:0] pix_x_o, pix_y_o;
  logic w_zero_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;

  bit      row_typed = 1'b0;
  screen_t row_res = '0;

  logic [63:0] mat [6];
  logic [13:0] scr_w, scr_h;
  screen_t pending [$];
  int errors = 0;
  int quiet = 0;
  bit calm = 1'b0;

  vertex_perspective_to_screen DUT (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic signed [63:0] clip_row(logic [63:0] r01, logic [63:0] r23,
                                                  logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
    logic signed [79:0] c0, c1, c2, c3, a, b, c, s;
    c0 = $signed(r01[31:0]);
    c1 = $signed(r01[63:32]);
    c2 = $signed(r23[31:0]);
    c3 = $signed(r23[63:32]);
    a = $signed(x);
    b = $signed(y);
    c = $signed(z);
    s = c0 * a + c1 * b + c2 * c + (c3 <<< 16);
    s = s >>> 16;
    return s[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] map_coord(logic signed [63:0] p, logic signed [63:0] w,
                                            logic [13:0] size);
    logic [127:0] mag, d, q;
    logic signed [127:0] r, cent;
    mag = p < 0 ? {64'b0, -p} : {64'b0, p};
    d = {64'b0, w} << 1;
    q = ((mag * {114'b0, size}) << 16) / d;
    if (q > (128'd1 << 33)) q = 128'd1 << 33;
    cent = $signed({99'b0, size, 15'b0});
    r = p < 0 ? -$signed(q) : $signed(q);
    return sat32(r + cent);
  endfunction

  function automatic logic [31:0] edge_coord(logic signed [63:0] p, logic [13:0] size);
    if (p > 0) return 32'h7FFF_FFFF;
    if (p < 0) return 32'h8000_0000;
    return {3'b0, size, 15'b0};
  endfunction

  function automatic bit project(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 output screen_t res);
    logic signed [63:0] px, py, pw;
    px = clip_row(mat[0], mat[1], x, y, z);
    py = clip_row(mat[2], mat[3], x, y, z);
    pw = clip_row(mat[4], mat[5], x, y, z);
    res = '0;
    if (pw < 0) return 1'b0;
    if (pw == 0) begin
      res.sx = edge_coord(px, scr_w);
      res.sy = edge_coord(py, scr_h);
      res.wz = 1'b1;
    end else begin
      res.sx = map_coord(px, pw, scr_w);
      res.sy = map_coord(py, pw, scr_h);
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    screen_t exp_res, got;
    if (!rst_ni) begin
      mat[0] = RstMX01; mat[1] = '0; mat[2] = RstMY01;
      mat[3] = '0; mat[4] = '0; mat[5] = RstMW23;
      scr_w = RstWidth; scr_h = RstHeight;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_idx_e'(cfg_index_i))
          REG_WIDTH:  scr_w = cfg_data_i[13:0];
          REG_HEIGHT: scr_h = cfg_data_i[13:0];
          default:    mat[cfg_index_i] = cfg_data_i;
        endcase
      end
      if (out_valid_o) begin
        got = '{pix_x_o, pix_y_o, w_zero_o};
        if (pending.size() == 0) begin
          $error("unexpected result x=%h y=%h wz=%b", got.sx, got.sy, got.wz);
          errors++;
        end else begin
          exp_res = pending.pop_front();
          if (got.sx !== exp_res.sx) begin
            $error("pix_x expected %h actual %h", exp_res.sx, got.sx);
            errors++;
          end
          if (got.sy !== exp_res.sy) begin
            $error("pix_y expected %h actual %h", exp_res.sy, got.sy);
            errors++;
          end
          if (got.wz !== exp_res.wz) begin
            $error("w_zero expected %b actual %b", exp_res.wz, got.wz);
            errors++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (project(vertex_x_i, vertex_y_i, vertex_z_i, exp_res))
          pending.push_back(row_typed ? row_res : exp_res);
      end
      if ((start_i && !busy_o) || out_valid_o || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
      if (quiet >= WdogMax) begin
        $display("vertex_perspective_to_screen test failed");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic end_writes();
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send(vrow_t r);
    if (!calm && $urandom_range(99) < 20) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    vertex_x_i <= r.vx;
    vertex_y_i <= r.vy;
    vertex_z_i <= r.vz;
    row_typed <= r.typed;
    row_res <= r.res;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    row_typed <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0: return $urandom();
      1: return '0;
      2: return 32'h0001_0000;
      default: return {{13{1'b0}}, 19'($urandom())} - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_vert();
    if ($urandom_range(9) == 0) return $urandom();
    return {{7{1'b0}}, 25'($urandom())} - 32'h0100_0000;
  endfunction

  function automatic logic [13:0] rand_size();
    case ($urandom_range(15))
      0: return 14'd0;
      1: return 14'd1;
      2: return 14'd8192;
      3: return 14'h3FFF;
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  vrow_t directed [$];

  initial begin
    vrow_t r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, '{32'd20971520, 32'd15728640, 1'b0}},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
      '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0, '0},
      '{32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, '0},
      '{32'h0064_8000, 32'hFF9C_4000, 32'h0, 1'b0, '0}
    };
    foreach (directed[i]) send(directed[i]);
    drain();

    write_reg(REG_M_W_01, '0);
    write_reg(REG_M_W_23, '0);
    end_writes();
    directed = '{
      '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
      '{32'h0, 32'h0, 32'h5, 1'b1, '{32'd20971520, 32'd15728640, 1'b1}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1}}
    };
    foreach (directed[i]) send(directed[i]);
    drain();

    write_reg(REG_M_W_23, NegHigh);
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd8192);
    end_writes();
    directed = '{
      '{32'h0, 32'h0, 32'h0, 1'b0, '0},
      '{32'h0001_0000, 32'h0002_0000, 32'h0, 1'b0, '0}
    };
    foreach (directed[i]) send(directed[i]);
    drain();
    write_reg(REG_M_W_23, OneHigh | 64'h0000_0000_0001_0000);
    end_writes();
    directed = '{
      '{32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'd268435456, 1'b0}},
      '{32'hFFFF_0000, 32'h0, 32'h0, 1'b0, '0},
      '{32'h0003_0000, 32'hFFF0_0000, 32'h0001_0000, 1'b0, '0},
      '{32'h0, 32'h0, 32'hFFFF_0000, 1'b0, '0}
    };
    foreach (directed[i]) send(directed[i]);
    drain();

    for (int ph = 0; ph < 13; ph++) begin
      if (ph == 0) begin
        write_reg(REG_M_X_01, '1);
        write_reg(REG_M_X_23, '1);
        write_reg(REG_M_Y_01, 64'h7FFF_FFFF_8000_0000);
        write_reg(REG_M_Y_23, 64'h8000_0000_7FFF_FFFF);
        write_reg(REG_M_W_01, '0);
        write_reg(REG_M_W_23, 64'h7FFF_FFFF_0000_0000);
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
      end else begin
        write_reg(REG_M_X_01, {rand_coef(), rand_coef()});
        write_reg(REG_M_X_23, {rand_coef(), rand_coef()});
        write_reg(REG_M_Y_01, {rand_coef(), rand_coef()});
        write_reg(REG_M_Y_23, {rand_coef(), rand_coef()});
        write_reg(REG_M_W_01, $urandom_range(2) == 0 ? {rand_coef(), rand_coef()}
                                                     : {$urandom_range(0, 4095),
                                                        $urandom_range(0, 4095)});
        write_reg(REG_M_W_23, {$urandom_range(3) == 0 ? rand_coef()
                                                      : 32'($urandom_range(1, 32'h0010_0000)),
                               rand_coef()});
        write_reg(REG_WIDTH, {$urandom(), $urandom()});
        write_reg(REG_HEIGHT, {50'b0, rand_size()});
        if ($urandom_range(1) == 0) write_reg(REG_WIDTH, {50'b0, rand_size()});
      end
      end_writes();
      calm = (ph == 6);
      for (int k = 0; k < 150; k++) begin
        r.vx = rand_vert();
        r.vy = rand_vert();
        r.vz = rand_vert();
        r.typed = 1'b0;
        r.res = '0;
        send(r);
      end
      drain();
    end

    if (errors == 0) begin
      $display("vertex_perspective_to_screen test passed");
    end else begin
      $display("vertex_perspective_to_screen test failed");
    end
    $finish;
  end
endmodule
